[hdl/mrrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrt_pkg
// Shared constants and types for the memory request reorder table.
// ----------------------------------------------------------------------------
package mrrt_pkg;

    localparam int ENTRIES        = 16;
    localparam int CORES          = 4;
    localparam int ROW_COLUMNS    = 1024;
    localparam int IDX_W          = $clog2(ENTRIES);
    localparam int SLOTS_PER_CORE = ENTRIES / CORES;
    // row is address divided by the row size, a power of two
    localparam int ROW_SHIFT      = $clog2(ROW_COLUMNS);

    localparam int ADDR_W = 20;
    localparam int DATA_W = 32;
    localparam int ROW_W  = 10;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_PICK   = 2'd1;
    localparam logic [1:0] MODE_RETIRE = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [1:0]        core;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] reg_data;
        logic [DATA_W-1:0] order;
        logic [DATA_W-1:0] fwd_value;
    } entry_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic             fwd;
        entry_t           ent;
    } cand_t;

endpackage

[hdl/mrrt_entry_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrt_entry_ram
// Entry payload store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mrrt_entry_ram (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [mrrt_pkg::IDX_W-1:0]  wr_addr,
    input  mrrt_pkg::entry_t            wr_data,
    input  logic [mrrt_pkg::IDX_W-1:0]  rd_addr,
    output mrrt_pkg::entry_t            rd_data
);

    mrrt_pkg::entry_t mem [mrrt_pkg::ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hdl/memory_request_reorder_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_request_reorder_table
// Pending request table with dependency tracking, forwarding and row-hit pick.
// ----------------------------------------------------------------------------
// sequence: insert and pick sweep the entry ram in ST_SCAN at one entry per
// cycle, then register their result beat from ST_DONE; retire and unknown
// modes go from ST_IDLE straight to ST_DONE, which waits on a stalled result
// flow: a new beat is taken only in ST_IDLE, once the result of the last one
// is registered; a new beat is taken while a result waits on the output
// reset: synchronous active-low aresetn clears valid, forward and dependency
// bits; the entry ram holds no reset and is read only under a valid bit
module memory_request_reorder_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode, core, is_store, mem_address, reg_or_data, seq_id, open_row,
    // retire_slot (lowest bit up)
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, slot, was_forwarded, forward_data, out_is_store, out_address,
    // out_reg_or_data, out_core (lowest bit up)
    output logic [95:0]  m_tdata
);

    localparam int IW = mrrt_pkg::IDX_W;
    localparam int EN = mrrt_pkg::ENTRIES;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [IW-1:0] cnt_reg;

    logic [1:0]                      op_mode_reg;
    logic [1:0]                      op_core_reg;
    logic                            op_kind_reg;
    logic [mrrt_pkg::ADDR_W-1:0]     op_addr_reg;
    logic [mrrt_pkg::DATA_W-1:0]     op_rd_reg;
    logic [mrrt_pkg::DATA_W-1:0]     op_ord_reg;
    logic [mrrt_pkg::ROW_W-1:0]      op_row_reg;
    logic [3:0]                      op_ret_reg;

    logic [EN-1:0] valid_reg;
    logic [EN-1:0] fwdv_reg;
    logic [EN-1:0] dep_reg [EN];

    logic [EN-1:0]               deps_acc_reg;
    logic                        fv_acc_reg;
    logic [mrrt_pkg::DATA_W-1:0] fval_acc_reg, ford_acc_reg;
    mrrt_pkg::cand_t             c_fwd_reg, c_row_reg, c_best_reg;

    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;

    mrrt_pkg::entry_t rd_data, wr_data;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;

    logic accept;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign rd_addr = (state_reg == ST_IDLE) ? '0 : cnt_reg + IW'(1);

    // free slot search over the core's range
    logic             free_found;
    logic [IW-1:0]    free_slot;
    logic [IW-1:0]    core_base;
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        core_base  = IW'(32'(op_core_reg) * mrrt_pkg::SLOTS_PER_CORE);
        if (32'(op_core_reg) < mrrt_pkg::CORES) begin
            for (int j = mrrt_pkg::SLOTS_PER_CORE - 1; j >= 0; j--) begin
                if (!valid_reg[core_base + IW'(j)]) begin
                    free_found = 1'b1;
                    free_slot  = core_base + IW'(j);
                end
            end
        end
    end

    logic finish;
    assign finish = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign wr_en  = finish && (op_mode_reg == mrrt_pkg::MODE_INSERT) && free_found;
    always_comb begin
        wr_data.kind      = op_kind_reg;
        wr_data.core      = op_core_reg;
        wr_data.addr      = op_addr_reg;
        wr_data.reg_data  = op_rd_reg;
        wr_data.order     = op_ord_reg;
        wr_data.fwd_value = fval_acc_reg;
    end

    mrrt_entry_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (free_slot),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // per-entry compare on the word coming out of the ram
    logic cur_v, cur_ready, cur_hit, cur_fwd_upd, cur_row_hit;
    always_comb begin
        cur_v     = valid_reg[cnt_reg] && (rd_data.core == op_core_reg);
        cur_ready = valid_reg[cnt_reg] && (dep_reg[cnt_reg] == '0);
        if (!rd_data.kind && !op_kind_reg) begin
            cur_hit = (rd_data.reg_data == op_rd_reg);
        end else begin
            cur_hit = (rd_data.addr == op_addr_reg);
        end
        cur_fwd_upd = cur_v && cur_hit && rd_data.kind && !op_kind_reg &&
                      (!fv_acc_reg || rd_data.order >= ford_acc_reg);
        cur_row_hit = (rd_data.addr >> mrrt_pkg::ROW_SHIFT) ==
                      mrrt_pkg::ADDR_W'(op_row_reg);
    end

    mrrt_pkg::cand_t cur_cand;
    always_comb begin
        cur_cand.found = 1'b1;
        cur_cand.idx   = cnt_reg;
        cur_cand.fwd   = fwdv_reg[cnt_reg];
        cur_cand.ent   = rd_data;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tdata[1:0] == mrrt_pkg::MODE_INSERT ||
                        s_tdata[1:0] == mrrt_pkg::MODE_PICK) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (cnt_reg == IW'(EN - 1)) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (finish) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result packing
    mrrt_pkg::cand_t pick_c;
    logic [95:0]     res;
    always_comb begin
        res    = '0;
        pick_c = c_best_reg;
        if (c_fwd_reg.found)      pick_c = c_fwd_reg;
        else if (c_row_reg.found) pick_c = c_row_reg;
        case (op_mode_reg)
            mrrt_pkg::MODE_INSERT: begin
                if (free_found) begin
                    res[1:0] = mrrt_pkg::STATUS_OK;
                    res[5:2] = 4'(free_slot);
                end else begin
                    res[1:0] = mrrt_pkg::STATUS_FULL;
                end
            end
            mrrt_pkg::MODE_PICK: begin
                if (pick_c.found) begin
                    res[1:0]   = mrrt_pkg::STATUS_OK;
                    res[5:2]   = 4'(pick_c.idx);
                    res[6]     = pick_c.fwd;
                    res[38:7]  = pick_c.fwd ? pick_c.ent.fwd_value : '0;
                    res[39]    = pick_c.ent.kind;
                    res[59:40] = pick_c.ent.addr;
                    res[91:60] = pick_c.ent.reg_data;
                    res[93:92] = pick_c.ent.core;
                end else begin
                    res[1:0] = mrrt_pkg::STATUS_EMPTY;
                end
            end
            mrrt_pkg::MODE_RETIRE: begin
                res[1:0] = mrrt_pkg::STATUS_OK;
                res[5:2] = op_ret_reg;
            end
            default: res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
            fwdv_reg     <= '0;
            for (int i = 0; i < EN; i++) dep_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                m_tvalid_reg <= 1'b1;
                if (wr_en) begin
                    valid_reg[free_slot] <= 1'b1;
                    fwdv_reg[free_slot]  <= fv_acc_reg;
                    dep_reg[free_slot]   <= deps_acc_reg;
                end
                if (op_mode_reg == mrrt_pkg::MODE_RETIRE &&
                    32'(op_ret_reg) < EN) begin
                    valid_reg[IW'(op_ret_reg)] <= 1'b0;
                    fwdv_reg[IW'(op_ret_reg)]  <= 1'b0;
                    for (int i = 0; i < EN; i++) dep_reg[i][IW'(op_ret_reg)] <= 1'b0;
                end
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) m_tdata_reg <= res;
        if (accept) begin
            op_mode_reg    <= s_tdata[1:0];
            op_core_reg    <= s_tdata[3:2];
            op_kind_reg    <= s_tdata[4];
            op_addr_reg    <= s_tdata[24:5];
            op_rd_reg      <= s_tdata[56:25];
            op_ord_reg     <= s_tdata[88:57];
            op_row_reg     <= s_tdata[98:89];
            op_ret_reg     <= s_tdata[102:99];
            cnt_reg        <= '0;
            deps_acc_reg   <= '0;
            fv_acc_reg     <= 1'b0;
            fval_acc_reg   <= '0;
            ford_acc_reg   <= '0;
            c_fwd_reg.found  <= 1'b0;
            c_row_reg.found  <= 1'b0;
            c_best_reg.found <= 1'b0;
        end else if (state_reg == ST_SCAN) begin
            cnt_reg <= cnt_reg + IW'(1);
            if (cur_v && cur_hit) deps_acc_reg[cnt_reg] <= 1'b1;
            if (cur_fwd_upd) begin
                fv_acc_reg   <= 1'b1;
                fval_acc_reg <= rd_data.reg_data;
                ford_acc_reg <= rd_data.order;
            end
            if (cur_ready) begin
                if (fwdv_reg[cnt_reg] && !c_fwd_reg.found) c_fwd_reg <= cur_cand;
                // later slot wins a tie on order
                if (cur_row_hit && (!c_row_reg.found ||
                    rd_data.order <= c_row_reg.ent.order)) c_row_reg <= cur_cand;
                if (!c_best_reg.found || rd_data.order <= c_best_reg.ent.order) begin
                    c_best_reg <= cur_cand;
                end
            end
        end
    end

endmodule

[hdl/mrrt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrt_checker
// Port-level checks for the memory request reorder table.
// ----------------------------------------------------------------------------
module mrrt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [103:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an operation is in flight");

    a_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == mrrt_pkg::STATUS_FULL ||
                     m_tdata[1:0] == mrrt_pkg::STATUS_EMPTY) |-> m_tdata[93:2] == '0)
        else $error("failed insert or pick carries payload");

    a_fwd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[6] |-> m_tdata[38:7] == '0)
        else $error("forward data without forward flag");

endmodule

bind memory_request_reorder_table mrrt_checker u_mrrt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[test/tb_memory_request_reorder_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_memory_request_reorder_table
// Drives insert, pick and retire beats into the request table, predicts each
// result with a behavioral copy of the table, and compares field by field.
// ----------------------------------------------------------------------------
module tb_memory_request_reorder_table;

    typedef struct packed {
        logic [3:0]  retire_slot;
        logic [9:0]  open_row;
        logic [31:0] seq_id;
        logic [31:0] reg_or_data;
        logic [19:0] mem_address;
        logic        is_store;
        logic [1:0]  core;
        logic [1:0]  mode;
    } req_t;

    typedef struct packed {
        logic [1:0]  out_core;
        logic [31:0] out_reg_or_data;
        logic [19:0] out_address;
        logic        out_is_store;
        logic [31:0] forward_data;
        logic        was_forwarded;
        logic [3:0]  slot;
        logic [1:0]  status;
    } rsp_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;

    memory_request_reorder_table dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of the table
    logic        tv [mrrt_pkg::ENTRIES];
    logic        tkind [mrrt_pkg::ENTRIES];
    logic [1:0]  tcore [mrrt_pkg::ENTRIES];
    logic [19:0] taddr [mrrt_pkg::ENTRIES];
    logic [31:0] tdat [mrrt_pkg::ENTRIES];
    logic [31:0] tord [mrrt_pkg::ENTRIES];
    logic        tfv [mrrt_pkg::ENTRIES];
    logic [31:0] tfval [mrrt_pkg::ENTRIES];
    logic [15:0] tdep [mrrt_pkg::ENTRIES];

    rsp_t expected_q[$];
    int   errors = 0;
    int   n_results = 0;
    int   n_fwd_picks = 0;
    int   n_full = 0;
    int   cycles = 0;
    bit   no_idle = 1'b0;

    function automatic rsp_t pick_result(int i);
        rsp_t r;
        r = '0;
        r.slot = i[3:0];
        r.was_forwarded = tfv[i];
        r.forward_data = tfv[i] ? tfval[i] : 32'd0;
        r.out_is_store = tkind[i];
        r.out_address = taddr[i];
        r.out_reg_or_data = tdat[i];
        r.out_core = tcore[i];
        return r;
    endfunction

    function automatic rsp_t table_step(req_t q);
        rsp_t r;
        int   s, br, b;
        logic [15:0] deps;
        logic fv;
        logic [31:0] fval, ford;
        logic hit;
        r = '0;
        case (q.mode)
            mrrt_pkg::MODE_INSERT: begin
                s = -1;
                for (int i = q.core * mrrt_pkg::SLOTS_PER_CORE;
                     i < (q.core + 1) * mrrt_pkg::SLOTS_PER_CORE; i++)
                    if (s < 0 && !tv[i]) s = i;
                if (s < 0) begin
                    r.status = mrrt_pkg::STATUS_FULL;
                end else begin
                    deps = '0; fv = 0; fval = 0; ford = 0;
                    for (int i = 0; i < mrrt_pkg::ENTRIES; i++) begin
                        if (tv[i] && tcore[i] == q.core) begin
                            if (!tkind[i] && !q.is_store) hit = (tdat[i] == q.reg_or_data);
                            else begin
                                hit = (taddr[i] == q.mem_address);
                                if (hit && tkind[i] && !q.is_store && (!fv || tord[i] >= ford)) begin
                                    fv = 1; fval = tdat[i]; ford = tord[i];
                                end
                            end
                            if (hit) deps[i] = 1'b1;
                        end
                    end
                    tv[s] = 1; tkind[s] = q.is_store; tcore[s] = q.core;
                    taddr[s] = q.mem_address; tdat[s] = q.reg_or_data;
                    tord[s] = q.seq_id; tfv[s] = fv; tfval[s] = fval; tdep[s] = deps;
                    r.status = mrrt_pkg::STATUS_OK;
                    r.slot = s[3:0];
                end
            end
            mrrt_pkg::MODE_PICK: begin
                // lowest ready slot with a forwarded value goes first
                for (int i = 0; i < mrrt_pkg::ENTRIES; i++)
                    if (tv[i] && tdep[i] == 0 && tfv[i]) return pick_result(i);
                br = -1; b = -1;
                for (int i = 0; i < mrrt_pkg::ENTRIES; i++) begin
                    if (tv[i] && tdep[i] == 0) begin
                        if ((taddr[i] >> mrrt_pkg::ROW_SHIFT) == q.open_row &&
                            (br < 0 || tord[i] <= tord[br])) br = i;
                        if (b < 0 || tord[i] <= tord[b]) b = i;
                    end
                end
                if (br >= 0) return pick_result(br);
                if (b >= 0) return pick_result(b);
                r.status = mrrt_pkg::STATUS_EMPTY;
            end
            mrrt_pkg::MODE_RETIRE: begin
                s = q.retire_slot;
                r.slot = q.retire_slot;
                for (int i = 0; i < mrrt_pkg::ENTRIES; i++) tdep[i][s] = 1'b0;
                tv[s] = 0; tfv[s] = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h want %0h", n_results, what, got, want);
        errors++;
    endtask

    // result side: random stalls and checking
    always @(posedge aclk) begin
        rsp_t g, e;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            g = m_tdata;
            n_results++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[31:0], 32'd0);
            end else begin
                e = expected_q.pop_front();
                if (g.status !== e.status) report_mismatch("status", g.status, e.status);
                if (g.slot !== e.slot) report_mismatch("slot", g.slot, e.slot);
                if (g.was_forwarded !== e.was_forwarded)
                    report_mismatch("was_forwarded", g.was_forwarded, e.was_forwarded);
                if (g.forward_data !== e.forward_data)
                    report_mismatch("forward_data", g.forward_data, e.forward_data);
                if (g.out_is_store !== e.out_is_store)
                    report_mismatch("out_is_store", g.out_is_store, e.out_is_store);
                if (g.out_address !== e.out_address)
                    report_mismatch("out_address", g.out_address, e.out_address);
                if (g.out_reg_or_data !== e.out_reg_or_data)
                    report_mismatch("out_reg_or_data", g.out_reg_or_data, e.out_reg_or_data);
                if (g.out_core !== e.out_core) report_mismatch("out_core", g.out_core, e.out_core);
                if (e.was_forwarded) n_fwd_picks++;
                if (e.status == mrrt_pkg::STATUS_FULL) n_full++;
            end
        end
    end

    int stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn || no_idle) begin
            m_tready <= aresetn;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (cycles > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one beat; an optional expected value typed in for the obvious rows
    task automatic send(req_t q, bit has_want = 0, rsp_t want = '0);
        rsp_t p;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tdata <= q;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        p = table_step(q);
        if (has_want && p != want) report_mismatch("directed row", p[31:0], want[31:0]);
        expected_q.push_back(p);
    endtask

    function automatic req_t mk(logic [1:0] m, logic [1:0] c, logic st, logic [19:0] a,
                                logic [31:0] d, logic [31:0] o, logic [9:0] row,
                                logic [3:0] rs);
        req_t q;
        q.mode = m; q.core = c; q.is_store = st; q.mem_address = a; q.reg_or_data = d;
        q.seq_id = o; q.open_row = row; q.retire_slot = rs;
        return q;
    endfunction

    typedef struct {
        req_t q;
        bit   has_want;
        rsp_t want;
    } row_t;

    function automatic rsp_t st_only(logic [1:0] s, logic [3:0] sl);
        rsp_t r;
        r = '0; r.status = s; r.slot = sl;
        return r;
    endfunction

    initial begin
        row_t dir[$];
        req_t q;
        int   live[$];
        int   k, c;
        logic [19:0] hot_addr [4];
        for (int i = 0; i < mrrt_pkg::ENTRIES; i++) begin
            tv[i] = 0; tfv[i] = 0; tdep[i] = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        dir.push_back('{mk(mrrt_pkg::MODE_PICK, 0, 0, 0, 0, 0, 10'h3ff, 0), 1,
                        st_only(mrrt_pkg::STATUS_EMPTY, 0)});
        dir.push_back('{mk(mrrt_pkg::MODE_INSERT, 0, 1, 20'hfffff, 32'h7fffffff,
                           32'hffffffff, 0, 0), 1, st_only(mrrt_pkg::STATUS_OK, 0)});
        dir.push_back('{mk(mrrt_pkg::MODE_INSERT, 0, 1, 20'hfffff, 32'h80000000,
                           32'hffffffff, 0, 0), 1, st_only(mrrt_pkg::STATUS_OK, 1)});
        dir.push_back('{mk(mrrt_pkg::MODE_INSERT, 0, 0, 20'hfffff, 32'd5, 32'd3, 0, 0),
                        1, st_only(mrrt_pkg::STATUS_OK, 2)});
        dir.push_back('{mk(mrrt_pkg::MODE_INSERT, 0, 0, 20'h00001, 32'd5, 32'd2, 0, 0),
                        1, st_only(mrrt_pkg::STATUS_OK, 3)});
        dir.push_back('{mk(mrrt_pkg::MODE_INSERT, 0, 0, 20'h0, 32'd9, 32'd0, 0, 0),
                        1, st_only(mrrt_pkg::STATUS_FULL, 0)});
        dir.push_back('{mk(mrrt_pkg::MODE_PICK, 0, 0, 0, 0, 0, 10'h3ff, 0), 0, '0});
        dir.push_back('{mk(mrrt_pkg::MODE_INSERT, 3, 0, 20'h00400, 32'hffffffff, 32'd0, 0, 0),
                        1, st_only(mrrt_pkg::STATUS_OK, 12)});
        dir.push_back('{mk(mrrt_pkg::MODE_INSERT, 3, 1, 20'h00800, 32'h1234, 32'd0, 0, 0),
                        1, st_only(mrrt_pkg::STATUS_OK, 13)});
        dir.push_back('{mk(mrrt_pkg::MODE_PICK, 0, 0, 0, 0, 0, 10'd2, 0), 0, '0});
        dir.push_back('{mk(mrrt_pkg::MODE_PICK, 0, 0, 0, 0, 0, 10'd1, 0), 0, '0});
        dir.push_back('{mk(mrrt_pkg::MODE_RETIRE, 0, 0, 0, 0, 0, 0, 4'd0), 1,
                        st_only(mrrt_pkg::STATUS_OK, 0)});
        dir.push_back('{mk(mrrt_pkg::MODE_RETIRE, 0, 0, 0, 0, 0, 0, 4'd1), 1,
                        st_only(mrrt_pkg::STATUS_OK, 1)});
        dir.push_back('{mk(mrrt_pkg::MODE_PICK, 0, 0, 0, 0, 0, 10'd0, 0), 0, '0});
        dir.push_back('{mk(mrrt_pkg::MODE_RETIRE, 0, 0, 0, 0, 0, 0, 4'd15), 1,
                        st_only(mrrt_pkg::STATUS_OK, 15)});
        dir.push_back('{mk(2'd3, 3, 1, 20'hfffff, 32'hffffffff, 32'hffffffff, 10'h3ff, 4'hf),
                        1, st_only(mrrt_pkg::STATUS_OK, 0)});
        for (int s = 0; s < mrrt_pkg::ENTRIES; s++)
            dir.push_back('{mk(mrrt_pkg::MODE_RETIRE, 0, 0, 0, 0, 0, 0, s[3:0]), 1,
                            st_only(mrrt_pkg::STATUS_OK, s[3:0])});
        dir = dir[0:24];
        foreach (dir[i]) send(dir[i].q, dir[i].has_want, dir[i].want);
        // clear whatever the table cut left behind
        for (int s = 0; s < mrrt_pkg::ENTRIES; s++)
            if (tv[s]) send(mk(mrrt_pkg::MODE_RETIRE, 0, 0, 0, 0, 0, 0, s[3:0]));

        // random: mostly well-formed traffic on two hot addresses per core, one row apart
        for (int i = 0; i < 4; i++) hot_addr[i] = 20'($urandom);
        for (int n = 0; n < 650; n++) begin
            if (n > 560) no_idle = 1'b1;
            q = 104'({$urandom, $urandom, $urandom, $urandom});
            k = $urandom_range(0, 99);
            if (k < 45) begin
                q.mode = mrrt_pkg::MODE_INSERT;
                c = q.core;
                if ($urandom_range(0, 2) != 0)
                    q.mem_address = hot_addr[c] ^ 20'($urandom_range(0, 1) << 10);
                if (!q.is_store && $urandom_range(0, 2) == 0) q.reg_or_data = $urandom_range(0, 3);
                if ($urandom_range(0, 1)) q.seq_id = n;
            end else if (k < 70) begin
                q.mode = mrrt_pkg::MODE_PICK;
                if ($urandom_range(0, 1))
                    q.open_row = 10'(hot_addr[q.core] >> mrrt_pkg::ROW_SHIFT);
            end else if (k < 97) begin
                q.mode = mrrt_pkg::MODE_RETIRE;
                live.delete();
                for (int s = 0; s < mrrt_pkg::ENTRIES; s++) if (tv[s]) live.push_back(s);
                if (live.size() > 0 && $urandom_range(0, 4) != 0)
                    q.retire_slot = 4'(live[$urandom_range(0, live.size() - 1)]);
            end else begin
                q.mode = 2'd3;
            end
            send(q);
        end
        s_tvalid <= 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("covered %0d results, %0d forwarded picks, %0d table-full inserts",
                 n_results, n_fwd_picks, n_full);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
hdl/mrrt_pkg.sv
hdl/mrrt_entry_ram.sv
hdl/memory_request_reorder_table.sv
hdl/mrrt_checker.sv
test/tb_memory_request_reorder_table.sv
